[rtl/core/odometry_position_integrator_core_macros.svh]
// assertion macros for the odometry position integrator
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ODOMETRY_POSITION_INTEGRATOR_CORE_MACROS_SVH
`define ODOMETRY_POSITION_INTEGRATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define OPI_ASSERT_NOW(lbl, clk_s, rst_n_s, pre, post, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication, disabled during reset
`define OPI_ASSERT_NEXT(lbl, clk_s, rst_n_s, pre, post, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (pre) |=> (post)) \
		else $error(msg);
`else
`define OPI_ASSERT_NOW(lbl, clk_s, rst_n_s, pre, post, msg)
`define OPI_ASSERT_NEXT(lbl, clk_s, rst_n_s, pre, post, msg)
`endif
`endif

[rtl/core/opi_pkg.sv]
// types, constants, sine table and microcode program of the odometry integrator
// no dependencies
`default_nettype none
package opi_pkg;

	localparam int TACHO_W            = 32;
	localparam int HEAD_W             = 9;
	localparam int POS_W              = 32;
	localparam int SCALE_W            = 16;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam int DIST_SHIFT         = 9;
	localparam int SINE_FRAC_BITS_DEF = 15;
	localparam int ROM_FRAC_BITS      = 15;
	localparam int ROM_W              = 16;
	localparam int ROM_DEPTH          = 91;
	localparam int ROM_IDX_W          = 7;
	localparam int DEG_QUARTER        = 90;
	localparam int DEG_HALF           = 180;
	localparam int DEG_THREE_QUARTER  = 270;
	localparam int DEG_FULL           = 360;

	localparam logic [ROM_W-1:0] SINE_ROM [ROM_DEPTH] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
		16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
		16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
		16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
		16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
		16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
		16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
		16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
		16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
		16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
		16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
	};

	typedef struct packed {
		logic signed [TACHO_W-1:0] tacho_right;
		logic signed [TACHO_W-1:0] tacho_left;
		logic [HEAD_W-1:0]         heading_deg;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_x;
		logic signed [POS_W-1:0] position_y;
		logic signed [POS_W-1:0] step_distance;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_SUM,
		OP_SUB_L,
		OP_SUB_R,
		OP_TRIG,
		OP_MUL_SCALE,
		OP_DIST,
		OP_MUL_SIN,
		OP_ACC_X,
		OP_MUL_COS,
		OP_ACC_Y,
		OP_ZERO_D,
		OP_COMMIT
	} op_t;

	typedef enum logic [1:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_NOT_PRIMED
	} jcond_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_FIRST  = 4'd0;
	localparam step_t STEP_PRIME  = 4'd10;
	localparam step_t STEP_COMMIT = 4'd11;
	localparam int    STEP_COUNT  = 12;

	typedef struct packed {
		op_t    op;
		jcond_t jc;
		step_t  target;
		logic   last;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t cw;
		cw = '{op: OP_NOP, jc: JC_NONE, target: STEP_FIRST, last: 1'b0};
		case (step)
			4'd0:  cw = '{op: OP_SUM,       jc: JC_NOT_PRIMED, target: STEP_PRIME,
				last: 1'b0};
			4'd1:  cw.op = OP_SUB_L;
			4'd2:  cw.op = OP_SUB_R;
			4'd3:  cw.op = OP_TRIG;
			4'd4:  cw.op = OP_MUL_SCALE;
			4'd5:  cw.op = OP_DIST;
			4'd6:  cw.op = OP_MUL_SIN;
			4'd7:  cw.op = OP_ACC_X;
			4'd8:  cw.op = OP_MUL_COS;
			4'd9:  cw = '{op: OP_ACC_Y,     jc: JC_ALWAYS, target: STEP_COMMIT, last: 1'b0};
			4'd10: cw.op = OP_ZERO_D;
			4'd11: cw = '{op: OP_COMMIT,    jc: JC_NONE, target: STEP_FIRST, last: 1'b1};
			default: cw = '{op: OP_NOP,     jc: JC_NONE, target: STEP_FIRST, last: 1'b1};
		endcase
		return cw;
	endfunction

endpackage
`default_nettype wire

[rtl/core/opi_stream_if.sv]
// valid/ready channel carrying one beat of a payload type
// payload types come from opi_pkg
`default_nettype none
interface opi_stream_if #(
	parameter type payload_t = opi_pkg::in_item_t
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/core/odometry_position_integrator_core.sv]
// odometry position integrator: microcoded sequencer over a shared multiplier datapath
// depends on opi_pkg, opi_stream_if and odometry_position_integrator_core_macros.svh
//
// One input beat gives one output beat. The block takes one item at a time. After the
// accept cycle the control program runs eleven of its twelve steps (three on the priming
// item, the first after reset), one step per cycle while it does not wait at its last
// step. The program walks through a single multiplier, used three times in turn (scale,
// sine, cosine) with a register after each product. A new item is taken as soon as the
// program ends, even while the previous output beat is still waiting. The program only
// waits at its last step when the output register is still full. distance_scale may be
// written whenever no item is in flight.
`default_nettype none
`include "odometry_position_integrator_core_macros.svh"
module odometry_position_integrator_core #(
	parameter int SINE_FRAC_BITS = opi_pkg::SINE_FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_write_en,
	input  wire logic [opi_pkg::SCALE_W-1:0]  cfg_write_data,
	opi_stream_if.sink                        in_ch,
	opi_stream_if.source                      out_ch
);

	localparam int SH_UP  = (SINE_FRAC_BITS > opi_pkg::ROM_FRAC_BITS) ?
		SINE_FRAC_BITS - opi_pkg::ROM_FRAC_BITS : 0;
	localparam int SH_DN  = (SINE_FRAC_BITS < opi_pkg::ROM_FRAC_BITS) ?
		opi_pkg::ROM_FRAC_BITS - SINE_FRAC_BITS : 0;
	localparam int TW      = opi_pkg::ROM_W + 1 + SH_UP;
	localparam int SINE_W  = SINE_FRAC_BITS + 2;
	localparam int MA_W    = opi_pkg::TACHO_W + 2;
	localparam int MB_W    = (SINE_W > opi_pkg::SCALE_W + 1) ? SINE_W : opi_pkg::SCALE_W + 1;
	localparam int P_W     = MA_W + MB_W;
	localparam int POS_W   = opi_pkg::POS_W;
	localparam int HEAD_W  = opi_pkg::HEAD_W;

	localparam logic [TW-1:0] ROUND_HALF = TW'((1 << SH_DN) >> 1);
	localparam logic signed [P_W-1:0] MASK_D = (P_W'(1) << opi_pkg::DIST_SHIFT) - P_W'(1);
	localparam logic signed [P_W-1:0] MASK_F = (P_W'(1) << SINE_FRAC_BITS) - P_W'(1);
	localparam logic signed [P_W-1:0] S32_MAX = {{(P_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
	localparam logic signed [P_W-1:0] S32_MIN = {{(P_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

	localparam logic [HEAD_W-1:0] D90  = HEAD_W'(opi_pkg::DEG_QUARTER);
	localparam logic [HEAD_W-1:0] D180 = HEAD_W'(opi_pkg::DEG_HALF);
	localparam logic [HEAD_W-1:0] D270 = HEAD_W'(opi_pkg::DEG_THREE_QUARTER);
	localparam logic [HEAD_W-1:0] D360 = HEAD_W'(opi_pkg::DEG_FULL);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	function automatic logic signed [SINE_W-1:0] trig_val(input logic [HEAD_W-1:0] h);
		logic [HEAD_W-1:0] idx;
		logic              neg;
		logic [TW-1:0]     scaled;
		logic [TW-1:0]     rounded;
		logic signed [SINE_W-1:0] mag;
		idx = h;
		neg = 1'b0;
		if (h <= D90) begin
			idx = h;
		end else if (h <= D180) begin
			idx = D180 - h;
		end else if (h <= D270) begin
			idx = h - D180;
			neg = 1'b1;
		end else begin
			idx = D360 - h;
			neg = 1'b1;
		end
		scaled  = TW'(opi_pkg::SINE_ROM[idx[opi_pkg::ROM_IDX_W-1:0]]) << SH_UP;
		rounded = (scaled + ROUND_HALF) >> SH_DN;
		mag     = rounded[SINE_W-1:0];
		return neg ? -mag : mag;
	endfunction

	function automatic logic signed [POS_W-1:0] sat32(input logic signed [P_W-1:0] v);
		if (v > S32_MAX) begin
			return S32_MAX[POS_W-1:0];
		end else if (v < S32_MIN) begin
			return S32_MIN[POS_W-1:0];
		end
		return v[POS_W-1:0];
	endfunction

	state_t                        state_q;
	opi_pkg::step_t                step_q;
	opi_pkg::ctrl_word_t           cw;
	logic                          out_valid_q;
	opi_pkg::out_item_t            out_data_q;
	logic                          out_free;
	logic                          step_go;
	logic                          in_accept;
	logic [opi_pkg::SCALE_W-1:0]   scale_q;
	logic                          primed_q;
	logic signed [POS_W-1:0]       prev_r_q;
	logic signed [POS_W-1:0]       prev_l_q;
	logic signed [POS_W-1:0]       x_q;
	logic signed [POS_W-1:0]       y_q;

	logic signed [POS_W-1:0]       r_q;
	logic signed [POS_W-1:0]       l_q;
	logic [HEAD_W-1:0]             h_q;
	logic [HEAD_W-1:0]             h_in;
	logic [HEAD_W-1:0]             cos_h;
	logic signed [MA_W-1:0]        a_q;
	logic signed [P_W-1:0]         prod_q;
	logic signed [POS_W-1:0]       d_q;
	logic signed [SINE_W-1:0]      sin_q;
	logic signed [SINE_W-1:0]      cos_q;

	logic signed [MA_W-1:0]        mul_a;
	logic signed [MB_W-1:0]        mul_b;
	logic signed [P_W-1:0]         biased_d;
	logic signed [P_W-1:0]         biased_f;
	logic signed [P_W-1:0]         dist_full;
	logic signed [P_W-1:0]         term_full;
	logic signed [POS_W:0]         term;
	logic signed [POS_W+1:0]       sum_x;
	logic signed [POS_W+1:0]       sum_y;

	assign cw        = opi_pkg::ucode(step_q);
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_accept = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign step_go   = (state_q == ST_RUN) && (!cw.last || out_free);
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_data_q;

	assign h_in  = (in_ch.payload.heading_deg >= D360) ?
		in_ch.payload.heading_deg - D360 : in_ch.payload.heading_deg;
	assign cos_h = (h_q + D90 >= D360) ? h_q + D90 - D360 : h_q + D90;

	// shared multiplier operand select
	always_comb begin
		mul_a = MA_W'(d_q);
		mul_b = MB_W'(cos_q);
		case (cw.op)
			opi_pkg::OP_MUL_SCALE: begin
				mul_a = a_q;
				mul_b = MB_W'(scale_q);
			end
			opi_pkg::OP_MUL_SIN: begin
				mul_b = MB_W'(sin_q);
			end
			default: begin
				mul_b = MB_W'(cos_q);
			end
		endcase
	end

	// truncating shifts toward zero
	assign biased_d  = prod_q + (prod_q[P_W-1] ? MASK_D : '0);
	assign biased_f  = prod_q + (prod_q[P_W-1] ? MASK_F : '0);
	assign dist_full = biased_d >>> opi_pkg::DIST_SHIFT;
	assign term_full = biased_f >>> SINE_FRAC_BITS;
	assign term      = term_full[POS_W:0];
	assign sum_x     = (POS_W+2)'(x_q) + (POS_W+2)'(term);
	assign sum_y     = (POS_W+2)'(y_q) + (POS_W+2)'(term);

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= opi_pkg::STEP_FIRST;
			out_valid_q <= 1'b0;
			scale_q     <= opi_pkg::SCALE_RESET;
			primed_q    <= 1'b0;
			prev_r_q    <= '0;
			prev_l_q    <= '0;
			x_q         <= '0;
			y_q         <= '0;
		end else begin
			if (cfg_write_en) begin
				scale_q <= cfg_write_data;
			end
			if (step_go && cw.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_RUN;
						step_q  <= opi_pkg::STEP_FIRST;
					end
				end
				ST_RUN: begin
					if (step_go) begin
						if (cw.last) begin
							state_q <= ST_IDLE;
						end else if ((cw.jc == opi_pkg::JC_ALWAYS) ||
							((cw.jc == opi_pkg::JC_NOT_PRIMED) && !primed_q)) begin
							step_q <= cw.target;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (step_go) begin
				case (cw.op)
					opi_pkg::OP_ACC_X: x_q <= sat32(P_W'(sum_x));
					opi_pkg::OP_ACC_Y: y_q <= sat32(P_W'(sum_y));
					opi_pkg::OP_COMMIT: begin
						prev_r_q <= r_q;
						prev_l_q <= l_q;
						primed_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			r_q <= in_ch.payload.tacho_right;
			l_q <= in_ch.payload.tacho_left;
			h_q <= h_in;
		end
		if (step_go) begin
			case (cw.op)
				opi_pkg::OP_SUM:       a_q <= MA_W'(r_q) + MA_W'(l_q);
				opi_pkg::OP_SUB_L:     a_q <= a_q - MA_W'(prev_l_q);
				opi_pkg::OP_SUB_R:     a_q <= a_q - MA_W'(prev_r_q);
				opi_pkg::OP_TRIG: begin
					sin_q <= trig_val(h_q);
					cos_q <= trig_val(cos_h);
				end
				opi_pkg::OP_MUL_SCALE: prod_q <= mul_a * mul_b;
				opi_pkg::OP_MUL_SIN:   prod_q <= mul_a * mul_b;
				opi_pkg::OP_MUL_COS:   prod_q <= mul_a * mul_b;
				opi_pkg::OP_DIST:      d_q <= sat32(dist_full);
				opi_pkg::OP_ZERO_D:    d_q <= '0;
				opi_pkg::OP_COMMIT: begin
					out_data_q.position_x    <= x_q;
					out_data_q.position_y    <= y_q;
					out_data_q.step_distance <= d_q;
				end
				default: ;
			endcase
		end
	end

	`OPI_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_accept, (state_q == ST_RUN) && (step_q == opi_pkg::STEP_FIRST), "accepted beat did not start the program")
	`OPI_ASSERT_NOW(a_step_range, clk, arst_n, state_q == ST_RUN, step_q < opi_pkg::STEP_W'(opi_pkg::STEP_COUNT), "step counter out of program")
	`OPI_ASSERT_NEXT(a_primed_holds, clk, arst_n, primed_q, primed_q, "primed flag dropped")
	`OPI_ASSERT_NOW(a_prime_zero, clk, arst_n, $rose(primed_q), out_valid_q && (out_data_q.step_distance == '0), "priming beat without zero distance")

endmodule
`default_nettype wire

[bench/opi_position_checker.sv]
// position checker for the odometry integrator: predicts each output beat from the
// accepted input beats and scale writes, then compares them in order
// depends on opi_pkg
module opi_position_checker #(
	parameter int SINE_FRAC_BITS = opi_pkg::SINE_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic [opi_pkg::SCALE_W-1:0]  cfg_write_data,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  opi_pkg::in_item_t            in_payload,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  opi_pkg::out_item_t           out_payload,
	output int                           error_count,
	output int                           pending_count,
	output int                           beats_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import opi_pkg::*;

	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	logic [SCALE_W-1:0] scale;
	longint             prev_right;
	longint             prev_left;
	bit                 primed;
	longint             acc_x;
	longint             acc_y;
	out_item_t          expected_positions[$];

	function automatic longint clamp_pos(longint v);
		if (v > POS_MAX) return POS_MAX;
		if (v < POS_MIN) return POS_MIN;
		return v;
	endfunction

	function automatic longint sine_entry(int k);
		longint s;
		int     up;
		int     dn;
		s  = longint'(SINE_ROM[k]);
		up = SINE_FRAC_BITS - ROM_FRAC_BITS;
		dn = ROM_FRAC_BITS - SINE_FRAC_BITS;
		if (up > 0) return s <<< up;
		if (dn > 0) return (s + ((64'sd1 <<< dn) >>> 1)) >>> dn;
		return s;
	endfunction

	function automatic longint sine_of(int h);
		if (h <= DEG_QUARTER) return sine_entry(h);
		if (h <= DEG_HALF) return sine_entry(DEG_HALF - h);
		if (h <= DEG_THREE_QUARTER) return -sine_entry(h - DEG_HALF);
		return -sine_entry(DEG_FULL - h);
	endfunction

	function automatic out_item_t advance_odometry(in_item_t it);
		longint    r;
		longint    l;
		longint    delta;
		longint    step_dist;
		longint    unit_div;
		int        hd;
		int        hc;
		out_item_t res;
		r    = longint'($signed(it.tacho_right));
		l    = longint'($signed(it.tacho_left));
		hd   = int'(it.heading_deg);
		step_dist = 0;
		if (hd >= DEG_FULL) hd -= DEG_FULL;
		hc = hd + DEG_QUARTER;
		if (hc >= DEG_FULL) hc -= DEG_FULL;
		if (primed) begin
			unit_div  = 64'sd1 <<< SINE_FRAC_BITS;
			delta     = r + l - prev_left - prev_right;
			step_dist = clamp_pos((delta * longint'(scale)) / 512);
			acc_x     = clamp_pos(acc_x + (step_dist * sine_of(hd)) / unit_div);
			acc_y     = clamp_pos(acc_y + (step_dist * sine_of(hc)) / unit_div);
		end
		primed     = 1'b1;
		prev_right = r;
		prev_left  = l;
		res.position_x    = acc_x[POS_W-1:0];
		res.position_y    = acc_y[POS_W-1:0];
		res.step_distance = step_dist[POS_W-1:0];
		return res;
	endfunction

	task automatic compare_field(string name, logic signed [POS_W-1:0] want,
		logic signed [POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			scale         = SCALE_RESET;
			prev_right    = 0;
			prev_left     = 0;
			primed        = 1'b0;
			acc_x         = 0;
			acc_y         = 0;
			error_count   = 0;
			beats_checked = 0;
			expected_positions.delete();
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_positions.size() == 0) begin
					$error("output beat with no expected position: x %0d y %0d d %0d",
						out_payload.position_x, out_payload.position_y,
						out_payload.step_distance);
					error_count++;
				end else begin
					want = expected_positions.pop_front();
					compare_field("position_x", want.position_x, out_payload.position_x);
					compare_field("position_y", want.position_y, out_payload.position_y);
					compare_field("step_distance", want.step_distance,
						out_payload.step_distance);
					beats_checked++;
				end
			end
			if (cfg_write_en) scale = cfg_write_data;
			if (in_valid && in_ready) expected_positions.push_back(advance_odometry(in_payload));
			pending_count <= expected_positions.size();
		end
	end

endmodule

[bench/tb_odometry_position_integrator_core.sv]
// testbench top for odometry_position_integrator_core: drives tacho/heading beats,
// distance scale writes and output back-pressure; the verdict comes from opi_position_checker
// depends on opi_pkg, opi_stream_if, the core and bench/opi_position_checker.sv
module tb_odometry_position_integrator_core;
	timeunit 1ns;
	timeprecision 1ps;
	import opi_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 300;
	localparam int PHASE_COUNT  = 5;
	localparam logic signed [TACHO_W-1:0] CNT_MAX = 32'sh7fffffff;
	localparam logic signed [TACHO_W-1:0] CNT_MIN = 32'sh80000000;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic [SCALE_W-1:0] cfg_write_data;
	int                 error_count;
	int                 pending_count;
	int                 beats_checked;

	bit                 tx_idle_en;
	bit                 rx_idle_en;
	int                 hold_asks;
	int                 holds_served;
	int                 beats_sent;
	int                 scale_writes;
	int                 cycles;
	logic signed [TACHO_W-1:0] last_right;
	logic signed [TACHO_W-1:0] last_left;

	opi_stream_if #(.payload_t(in_item_t))  in_ch ();
	opi_stream_if #(.payload_t(out_item_t)) out_ch ();

	odometry_position_integrator_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_ch          (in_ch),
		.out_ch         (out_ch)
	);

	opi_position_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_ch.valid),
		.in_ready       (in_ch.ready),
		.in_payload     (in_ch.payload),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.out_payload    (out_ch.payload),
		.error_count    (error_count),
		.pending_count  (pending_count),
		.beats_checked  (beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [TACHO_W-1:0] next_count(logic signed [TACHO_W-1:0] prev);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) return prev + (int'($urandom_range(4000)) - 2000);
		if (pick < 84) return prev + (int'($urandom_range(2000000)) - 1000000);
		if (pick < 92) return $urandom();
		case ($urandom_range(3))
			0: return CNT_MAX;
			1: return CNT_MIN;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [HEAD_W-1:0] pick_heading();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 85) return HEAD_W'($urandom_range(DEG_FULL - 1));
		if (pick < 90) return HEAD_W'(DEG_FULL);
		return HEAD_W'($urandom_range((1 << HEAD_W) - 1, DEG_FULL + 1));
	endfunction

	task automatic send_counts(logic signed [TACHO_W-1:0] r, logic signed [TACHO_W-1:0] l,
		logic [HEAD_W-1:0] h);
		while (tx_idle_en && $urandom_range(99) < 34) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= in_item_t'{tacho_right: r, tacho_left: l, heading_deg: h};
		do @(posedge clk); while (!in_ch.ready);
		last_right = r;
		last_left  = l;
		beats_sent++;
	endtask

	task automatic end_burst();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] v);
		end_burst();
		repeat (4) @(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		scale_writes++;
	endtask

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		int n;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_asks != holds_served) begin
				holds_served++;
				for (n = 0; n < HOLD_CYCLES; n++) begin
					out_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			out_ch.ready <= !(rx_idle_en && $urandom_range(99) < 34);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int               ph;
		int               n;
		logic [SCALE_W-1:0] sc;
		arst_n         = 1'b0;
		in_ch.valid    <= 1'b0;
		in_ch.payload  <= '0;
		cfg_write_en   <= 1'b0;
		cfg_write_data <= '0;
		tx_idle_en     = 1'b1;
		rx_idle_en     = 1'b1;
		hold_asks      = 0;
		holds_served   = 0;
		beats_sent     = 0;
		scale_writes   = 0;
		last_right     = '0;
		last_left      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset scale: priming beat, quadrant edges, truncation, saturation
		send_counts(1000, -500, 300);
		send_counts(1003, -500, 0);
		send_counts(1000, -500, 45);
		send_counts(2000, 500, 90);
		send_counts(-1, -1, 180);
		send_counts(0, 0, 270);
		send_counts(CNT_MAX, CNT_MAX, DEG_FULL);
		send_counts(CNT_MIN, CNT_MIN, 511);
		send_counts(CNT_MAX, CNT_MAX, 90);
		send_counts(CNT_MIN, CNT_MIN, 270);
		send_counts(CNT_MAX, CNT_MAX, 0);
		send_counts(CNT_MIN, CNT_MIN, 180);
		send_counts(0, -1, 1);
		send_counts(-100, 33, 91);
		send_counts(4000, 4000, 181);
		send_counts(77, -77, 271);
		send_counts(1, 1, 359);
		send_counts(-9, 2, 361);

		write_scale('0);
		send_counts(CNT_MAX, CNT_MIN, 45);
		send_counts(CNT_MIN, CNT_MAX, 135);

		write_scale('1);
		send_counts(CNT_MAX, CNT_MAX, 30);
		send_counts(CNT_MIN, CNT_MIN, 300);
		send_counts(1000000, 1000000, 450);

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: sc = SCALE_W'($urandom_range(1024, 1));
				1: sc = '1;
				2: sc = SCALE_W'($urandom());
				3: sc = SCALE_W'(1);
				default: sc = SCALE_W'($urandom_range(512, 128));
			endcase
			write_scale(sc);
			tx_idle_en = (ph != 1);
			rx_idle_en = (ph != 1);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 40) hold_asks++;
				send_counts(next_count(last_right), next_count(last_left), pick_heading());
			end
		end

		end_burst();
		repeat (20) @(posedge clk);
		$display("sent %0d tacho/heading beats over %0d distance scale settings",
			beats_sent, scale_writes);
		$display("checked %0d position beats, %0d mismatches", beats_checked, error_count);
		if (error_count == 0 && pending_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
